@@ hw/rtl/mpp_pkg.sv @@
// Shared types, constants and sequencer states for the max-pool peak picker.
// Used by every module under hw/rtl; depends on nothing.
package mpp_pkg;

    localparam int unsigned POOL_KERNEL_DEF = 7;
    localparam int unsigned FRAME_BITS_DEF  = 20;
    localparam int unsigned LOGIT_W         = 16;
    localparam int unsigned POS_W           = 21;
    localparam int unsigned MAX_RESULTS     = 3;
    localparam int unsigned CNT_W           = 2;

    typedef logic signed [LOGIT_W-1:0] logit_t;
    typedef logic [POS_W-1:0]          pos_t;
    typedef logic [CNT_W-1:0]          cnt_t;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_DRAIN,
        ST_FINAL
    } seq_state_t;

    typedef struct packed {
        logit_t logit;
        logic   last;
    } in_word_t;

    typedef struct packed {
        logic step;
        logic shift_valid;
        logic center_en;
        logic excl_low;
        logic clear;
    } win_ctrl_t;

    typedef struct packed {
        logic step;
        logic peak;
        logic allow_emit;
        logic clear;
    } grp_ctrl_t;

    typedef struct packed {
        logic valid;
        logic peak_valid;
        logic end_of_run;
        pos_t position;
    } result_t;

endpackage

@@ hw/rtl/mpp_in_skid.sv @@
// Input skid pair for the peak picker: main and spare word registers.
// Keeps the upstream stall registered. Depends on mpp_pkg.
module mpp_in_skid
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  mpp_pkg::in_word_t in_word,
    input  logic             take,
    output logic             word_valid,
    output mpp_pkg::in_word_t word
);

    logic              main_valid_reg, main_valid_next;
    logic              spare_valid_reg, spare_valid_next;
    mpp_pkg::in_word_t main_reg, main_next;
    mpp_pkg::in_word_t spare_reg, spare_next;
    logic              push;
    logic              pop;

    assign in_stall   = spare_valid_reg;
    assign word_valid = main_valid_reg;
    assign word       = main_reg;
    assign push       = in_valid && !spare_valid_reg;
    assign pop        = main_valid_reg && take;

    always_comb
    begin
        main_valid_next  = main_valid_reg;
        spare_valid_next = spare_valid_reg;
        main_next        = main_reg;
        spare_next       = spare_reg;
        if (pop)
        begin
            if (spare_valid_reg)
            begin
                main_next        = spare_reg;
                spare_valid_next = 1'b0;
            end
            else if (push)
            begin
                main_next = in_word;
            end
            else
            begin
                main_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg)
            begin
                main_next       = in_word;
                main_valid_next = 1'b1;
            end
            else
            begin
                spare_next       = in_word;
                spare_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg  <= 1'b0;
            spare_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg  <= main_valid_next;
            spare_valid_reg <= spare_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg  <= main_next;
        spare_reg <= spare_next;
    end

endmodule

@@ hw/rtl/mpp_window.sv @@
// Sliding logit window with per-slot valid bits and the center peak test.
// Depends on mpp_pkg.
module mpp_window
#(
    parameter int unsigned POOL_KERNEL = mpp_pkg::POOL_KERNEL_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  mpp_pkg::win_ctrl_t ctrl,
    input  mpp_pkg::logit_t    shift_logit,
    input  mpp_pkg::logit_t    threshold,
    output logic               peak,
    output logic               center_valid
);

    localparam int unsigned HALF_K = POOL_KERNEL / 2;
    localparam int unsigned NW     = 2 * HALF_K + 1;
    localparam bit          EVEN_K = (NW != POOL_KERNEL);

    mpp_pkg::logit_t win_reg [NW];
    mpp_pkg::logit_t win_next [NW];
    mpp_pkg::logit_t sh_win [NW];
    logic [NW-1:0]   wv_reg, wv_next;
    logic [NW-1:0]   sh_v;
    mpp_pkg::logit_t center;

    always_comb
    begin
        for (int i = 0; i < int'(NW) - 1; i++)
        begin
            sh_win[i] = win_reg[i+1];
        end
        sh_win[NW-1] = shift_logit;
        sh_v         = {ctrl.shift_valid, wv_reg[NW-1:1]};
    end

    assign center_valid = sh_v[HALF_K];
    assign center       = sh_win[HALF_K];

    always_comb
    begin
        peak = 1'b0;
        if (ctrl.center_en && sh_v[HALF_K] && (center > threshold))
        begin
            peak = 1'b1;
            for (int i = 0; i < int'(NW); i++)
            begin
                if ((i != int'(HALF_K)) && sh_v[i] && !(i == 0 && EVEN_K && ctrl.excl_low)
                    && (sh_win[i] > center))
                begin
                    peak = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        win_next = win_reg;
        wv_next  = wv_reg;
        if (ctrl.clear)
        begin
            wv_next = '0;
        end
        else if (ctrl.step)
        begin
            win_next = sh_win;
            wv_next  = sh_v;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wv_reg <= '0;
        end
        else
        begin
            wv_reg <= wv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

endmodule

@@ hw/rtl/mpp_group.sv @@
// Peak grouping: merges a peak within one frame of a single-peak group.
// Takes frame positions; group means are signed half frames. Depends on mpp_pkg.
module mpp_group
#(
    parameter int unsigned FRAME_BITS = mpp_pkg::FRAME_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  mpp_pkg::grp_ctrl_t    ctrl,
    input  logic [FRAME_BITS+1:0] pos,
    output logic                  emit,
    output logic [FRAME_BITS+1:0] mean_half,
    output logic                  open,
    output logic                  size2
);

    localparam int unsigned GW = FRAME_BITS + 2;

    logic          open_reg, open_next;
    logic          size2_reg, size2_next;
    logic [GW-1:0] gm_reg, gm_next;
    logic [GW-1:0] ph;
    logic [GW-1:0] diff;
    logic [GW-1:0] merged;
    logic          join_grp;

    assign ph       = {pos[GW-2:0], 1'b0};
    assign diff     = ph - gm_reg;
    assign merged   = {gm_reg[GW-1], gm_reg[GW-1:1]} + pos;
    assign join_grp = open_reg && !size2_reg && (ph >= gm_reg) && (diff <= GW'(2));

    assign mean_half = gm_reg;
    assign open      = open_reg;
    assign size2     = size2_reg;

    always_comb
    begin
        open_next  = open_reg;
        size2_next = size2_reg;
        gm_next    = gm_reg;
        emit       = 1'b0;
        if (ctrl.clear)
        begin
            open_next  = 1'b0;
            size2_next = 1'b0;
        end
        else if (ctrl.step && ctrl.peak)
        begin
            if (join_grp)
            begin
                gm_next    = merged;
                size2_next = 1'b1;
            end
            else
            begin
                emit       = open_reg && ctrl.allow_emit;
                open_next  = 1'b1;
                size2_next = 1'b0;
                gm_next    = ph;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg  <= 1'b0;
            size2_reg <= 1'b0;
        end
        else
        begin
            open_reg  <= open_next;
            size2_reg <= size2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        gm_reg <= gm_next;
    end

endmodule

@@ hw/rtl/maxpool_peak_picker_core.sv @@
// Max-pool peak picker top level: skid input, window, grouping, sequencer, output register.
// Depends on mpp_pkg, mpp_in_skid, mpp_window and mpp_group.
//
// Takes one logit word per cycle while running with a free output register, and decides
// the frame POOL_KERNEL/2 words back in the same cycle, so results trail their frame by
// POOL_KERNEL/2 words plus the input register and the output register. After a word
// flagged last_frame, the window shifts out its remaining frames one per cycle while
// the output is free, through the same compare logic; then the final state flushes the
// open group or the empty end marker and clears the sequence state. Input is not taken
// during that tail. The output register advances when empty or when out_stall is low;
// in_stall comes from a register. The peak threshold is written via cfg_we/cfg_wdata.
module maxpool_peak_picker_core
#(
    parameter int unsigned POOL_KERNEL = mpp_pkg::POOL_KERNEL_DEF,
    parameter int unsigned FRAME_BITS  = mpp_pkg::FRAME_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [mpp_pkg::LOGIT_W-1:0] cfg_wdata,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [mpp_pkg::LOGIT_W-1:0] logit,
    input  logic                        last_frame,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [mpp_pkg::POS_W-1:0]   peak_position,
    output logic                        peak_valid,
    output logic                        end_of_run
);

    localparam int unsigned HALF_K = POOL_KERNEL / 2;
    localparam int unsigned GW     = FRAME_BITS + 2;
    localparam int unsigned PW     = mpp_pkg::POS_W;
    localparam int unsigned D_W    = $clog2(HALF_K + 1);
    localparam int unsigned CW     = mpp_pkg::CNT_W;

    mpp_pkg::seq_state_t state_reg, state_next;
    logic [FRAME_BITS-1:0] frame_reg, frame_next;
    logic [GW-1:0]         dpos_reg, dpos_next;
    logic [D_W-1:0]        d_reg, d_next;
    mpp_pkg::cnt_t         cnt_reg, cnt_next;
    mpp_pkg::logit_t       thr_reg;

    logic                  out_valid_reg;
    mpp_pkg::result_t      out_reg;

    mpp_pkg::in_word_t     in_word;
    mpp_pkg::in_word_t     word;
    logic                  word_valid;
    logic                  take;
    logic                  out_free;

    mpp_pkg::win_ctrl_t    wctrl;
    mpp_pkg::grp_ctrl_t    gctrl;
    mpp_pkg::logit_t       shift_logit;
    logic                  peak;
    logic                  center_valid;
    logic [GW-1:0]         cur_pos;
    logic                  last_seq;
    logic                  g_emit;
    logic [GW-1:0]         g_half;
    logic                  g_open;
    logic                  g_size2;
    mpp_pkg::result_t      res;

    assign in_word.logit = logit;
    assign in_word.last  = last_frame;

    assign out_free = !out_valid_reg || !out_stall;
    assign take     = word_valid && out_free && (state_reg == mpp_pkg::ST_RUN);

    mpp_in_skid u_skid
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_word    (in_word),
        .take       (take),
        .word_valid (word_valid),
        .word       (word)
    );

    mpp_window #(.POOL_KERNEL(POOL_KERNEL)) u_window
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (wctrl),
        .shift_logit  (shift_logit),
        .threshold    (thr_reg),
        .peak         (peak),
        .center_valid (center_valid)
    );

    mpp_group #(.FRAME_BITS(FRAME_BITS)) u_group
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (gctrl),
        .pos       (cur_pos),
        .emit      (g_emit),
        .mean_half (g_half),
        .open      (g_open),
        .size2     (g_size2)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mpp_pkg::ST_RUN:
            begin
                if (take && word.last)
                begin
                    state_next = mpp_pkg::ST_DRAIN;
                end
            end
            mpp_pkg::ST_DRAIN:
            begin
                if (out_free && (d_reg == D_W'(HALF_K)))
                begin
                    state_next = mpp_pkg::ST_FINAL;
                end
            end
            mpp_pkg::ST_FINAL:
            begin
                if (out_free)
                begin
                    state_next = mpp_pkg::ST_RUN;
                end
            end
            default:
            begin
                state_next = mpp_pkg::ST_RUN;
            end
        endcase
    end

    // datapath control and result
    always_comb
    begin
        wctrl       = '0;
        shift_logit = '0;
        cur_pos     = dpos_reg;
        last_seq    = 1'b0;
        gctrl       = '0;
        res         = '0;
        unique case (state_reg)
            mpp_pkg::ST_RUN:
            begin
                wctrl.step        = take;
                wctrl.shift_valid = 1'b1;
                wctrl.excl_low    = 1'b1;
                wctrl.center_en   = word.last ? center_valid
                                              : (frame_reg >= FRAME_BITS'(HALF_K));
                shift_logit       = word.logit;
                cur_pos           = GW'(frame_reg) - GW'(HALF_K);
                last_seq          = word.last;
            end
            mpp_pkg::ST_DRAIN:
            begin
                wctrl.step      = out_free;
                wctrl.center_en = 1'b1;
                last_seq        = 1'b1;
            end
            mpp_pkg::ST_FINAL:
            begin
                wctrl.clear = out_free;
                gctrl.clear = out_free;
                last_seq    = 1'b1;
            end
            default:
            begin
                last_seq = 1'b0;
            end
        endcase

        gctrl.step       = wctrl.step;
        gctrl.peak       = peak;
        gctrl.allow_emit = !last_seq || (cnt_reg != CW'(mpp_pkg::MAX_RESULTS));

        if (state_reg == mpp_pkg::ST_FINAL)
        begin
            if (out_free && (cnt_reg != CW'(mpp_pkg::MAX_RESULTS)))
            begin
                if (g_open)
                begin
                    res.valid      = 1'b1;
                    res.peak_valid = 1'b1;
                    res.end_of_run = 1'b1;
                    res.position   = PW'($signed(g_half));
                end
                else if (cnt_reg == '0)
                begin
                    res.valid      = 1'b1;
                    res.end_of_run = 1'b1;
                end
            end
        end
        else
        begin
            res.valid      = g_emit;
            res.peak_valid = 1'b1;
            res.end_of_run = last_seq && (cnt_reg == CW'(mpp_pkg::MAX_RESULTS - 1));
            res.position   = PW'($signed(g_half));
        end
    end

    // sequence counters
    always_comb
    begin
        frame_next = frame_reg;
        dpos_next  = dpos_reg;
        d_next     = d_reg;
        cnt_next   = cnt_reg;
        if (take)
        begin
            if (word.last)
            begin
                frame_next = '0;
                dpos_next  = cur_pos + GW'(1);
                d_next     = D_W'(1);
            end
            else
            begin
                frame_next = frame_reg + FRAME_BITS'(1);
            end
        end
        else if ((state_reg == mpp_pkg::ST_DRAIN) && out_free)
        begin
            dpos_next = dpos_reg + GW'(1);
            if (d_reg != D_W'(HALF_K))
            begin
                d_next = d_reg + D_W'(1);
            end
        end
        if ((state_reg == mpp_pkg::ST_FINAL) && out_free)
        begin
            cnt_next = '0;
        end
        else if (res.valid && last_seq)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mpp_pkg::ST_RUN;
            frame_reg     <= '0;
            d_reg         <= '0;
            cnt_reg       <= '0;
            thr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            frame_reg <= frame_next;
            d_reg     <= d_next;
            cnt_reg   <= cnt_next;
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
            if (out_free)
            begin
                out_valid_reg <= res.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dpos_reg <= dpos_next;
        if (out_free && res.valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign peak_position = out_reg.position;
    assign peak_valid    = out_reg.peak_valid;
    assign end_of_run    = out_reg.end_of_run;

`ifndef ASSERT_OFF
    a_marker_form: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.peak_valid) |->
            (out_reg.end_of_run && (out_reg.position == '0)))
        else $error("end marker without end_of_run or with nonzero position");

    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == mpp_pkg::ST_FINAL) && out_free) |=>
            ((state_reg == mpp_pkg::ST_RUN) && (frame_reg == '0) && (cnt_reg == '0)
             && !g_open))
        else $error("sequence state not cleared after flush");

    a_pair_open: assert property (@(posedge clk) disable iff (!rst_n)
        g_size2 |-> g_open)
        else $error("two-peak group recorded while no group is open");

    a_cap_results: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && last_seq) |-> (cnt_reg != CW'(mpp_pkg::MAX_RESULTS)))
        else $error("result beyond the per-word limit");
`endif

endmodule
